// File: sv/polygon_rect_overlap_test_core_macros.svh
// Assertion macros for the polygon/rectangle overlap test core.
// Used by the port checker; expects clk_i and rst_ni in scope.
`ifndef POLYGON_RECT_OVERLAP_TEST_CORE_MACROS_SVH
`define POLYGON_RECT_OVERLAP_TEST_CORE_MACROS_SVH

// Check a property outside reset
`define PROT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check a property at every edge, reset included
`define PROT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: sv/prot_pkg.sv
// Shared types, widths and helpers for the polygon/rectangle overlap test.
// No dependencies; imported by the controller, the datapath and the top level.
`timescale 1ns / 1ps
`default_nettype none

package prot_pkg;

  localparam int COORD_WIDTH    = 32;
  localparam int DIFF_WIDTH     = COORD_WIDTH + 1;
  localparam int PROD_WIDTH     = 2 * DIFF_WIDTH;
  localparam int CFG_ADDR_WIDTH = 3;

  // Register indexes
  localparam logic [CFG_ADDR_WIDTH-1:0] REG_LEFT   = CFG_ADDR_WIDTH'(0);
  localparam logic [CFG_ADDR_WIDTH-1:0] REG_RIGHT  = CFG_ADDR_WIDTH'(1);
  localparam logic [CFG_ADDR_WIDTH-1:0] REG_TOP    = CFG_ADDR_WIDTH'(2);
  localparam logic [CFG_ADDR_WIDTH-1:0] REG_BOTTOM = CFG_ADDR_WIDTH'(3);

  // Products formed per edge by the shared multiplier
  typedef enum logic [1:0] {
    PROD_LSX_DY,
    PROD_RSX_DY,
    PROD_TSY_DX,
    PROD_BSY_DX
  } prod_sel_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic      capture;
    logic      first;
    logic      setup;
    logic      closing;
    logic      mul;
    prod_sel_e mul_sel;
    logic      eval_x;
    logic      eval_y;
    logic      emit;
  } prot_cmd_t;

  // lo <= s + n/d <= hi with a = (lo-s)*d, b = (hi-s)*d; no crossing when d is zero
  function automatic logic cross_test(input logic signed [PROD_WIDTH-1:0] n,
                                      input logic signed [PROD_WIDTH-1:0] a,
                                      input logic signed [PROD_WIDTH-1:0] b,
                                      input logic d_pos,
                                      input logic d_zero);
    logic res;
    if (d_zero) begin
      res = 1'b0;
    end else if (d_pos) begin
      res = (a <= n) && (n <= b);
    end else begin
      res = (n <= a) && (b <= n);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// File: sv/polygon_rect_overlap_test_core.sv
// Top level of the polygon/rectangle overlap test: joins controller and datapath.
// Depends on prot_pkg, prot_ctrl and prot_dp.
//
//   channel   direction  payload
//   s_axis    in         tdata = vertex_x, vertex_y; tlast = last_vertex
//   m_axis    out        tdata = overlaps (zero padded to 8 bits)
//   cfg       in         write of rect_left/right/top/bottom by index
//
// A vertex is captured, then each tested edge runs setup, four products through
// the one shared 33x33 multiplier and two compare steps. The first vertex is
// only captured; a middle vertex tests its edge; the last vertex tests its edge
// and then the closing edge (only the closing edge if also first), then hands off.
// A pending result waits in the output register; a new last vertex stalls
// at the handoff until it is taken. Reset is asynchronous and clears control.
`timescale 1ns / 1ps
`default_nettype none

module polygon_rect_overlap_test_core import prot_pkg::*; (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      s_axis_tvalid,
  output logic                           s_axis_tready,
  input  wire logic [2*COORD_WIDTH-1:0]  s_axis_tdata,  // vertex_x, vertex_y
  input  wire logic                      s_axis_tlast,  // last_vertex
  output logic                           m_axis_tvalid,
  input  wire logic                      m_axis_tready,
  output logic [7:0]                     m_axis_tdata,  // overlaps, zeros
  input  wire logic                      cfg_we_i,
  input  wire logic [CFG_ADDR_WIDTH-1:0] cfg_addr_i,
  input  wire logic [COORD_WIDTH-1:0]    cfg_wdata_i
);

  prot_cmd_t cmd;
  logic      overlaps;

  prot_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tlast_i  (s_axis_tlast),
    .s_tready_o (s_axis_tready),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .cmd_o      (cmd)
  );

  prot_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .vertex_x_i  (s_axis_tdata[COORD_WIDTH-1:0]),
    .vertex_y_i  (s_axis_tdata[2*COORD_WIDTH-1:COORD_WIDTH]),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .overlaps_o  (overlaps)
  );

  assign m_axis_tdata = {7'd0, overlaps};

endmodule

`default_nettype wire

// File: sv/prot_dp.sv
// Datapath: rectangle registers, stored vertices, edge differences,
// one shared 33x33 multiplier and the exact crossing compares. Uses prot_pkg.
`timescale 1ns / 1ps
`default_nettype none

module prot_dp import prot_pkg::*; (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire prot_cmd_t                     cmd_i,
  input  wire logic signed [COORD_WIDTH-1:0] vertex_x_i,
  input  wire logic signed [COORD_WIDTH-1:0] vertex_y_i,
  input  wire logic                          cfg_we_i,
  input  wire logic [CFG_ADDR_WIDTH-1:0]     cfg_addr_i,
  input  wire logic [COORD_WIDTH-1:0]        cfg_wdata_i,
  output logic                               overlaps_o
);

  logic signed [COORD_WIDTH-1:0] left_q, right_q, top_q, bottom_q;
  logic signed [COORD_WIDTH-1:0] first_x_q, first_y_q, prev_x_q, prev_y_q;
  logic signed [COORD_WIDTH-1:0] cur_x_q, cur_y_q;
  logic signed [DIFF_WIDTH-1:0]  dx_q, dy_q, lsx_q, rsx_q, tsy_q, bsy_q;
  logic                          xin_q, yin_q, ins_q, cx1_q, cx2_q;
  logic                          hit_q, out_q;
  logic signed [PROD_WIDTH-1:0]  prod_q [4];

  logic signed [COORD_WIDTH-1:0] sx, sy, ex, ey;
  logic signed [DIFF_WIDTH-1:0]  mul_a, mul_b;
  logic signed [PROD_WIDTH-1:0]  mul_p;
  logic                          xin, yin, ins, cx1, cx2, cy1, cy2, edge_hit;
  logic                          dx_pos, dx_zero, dy_pos, dy_zero;

  // Select the edge endpoints
  always_comb begin
    sx = cmd_i.closing ? cur_x_q : prev_x_q;
    sy = cmd_i.closing ? cur_y_q : prev_y_q;
    ex = cmd_i.closing ? first_x_q : cur_x_q;
    ey = cmd_i.closing ? first_y_q : cur_y_q;
  end

  // Span and endpoint-inside tests
  always_comb begin
    xin = ((sx < left_q) && (left_q < ex)) || ((ex < left_q) && (left_q < sx)) ||
          ((sx < right_q) && (right_q < ex)) || ((ex < right_q) && (right_q < sx));
    yin = ((sy < top_q) && (top_q < ey)) || ((ey < top_q) && (top_q < sy)) ||
          ((sy < bottom_q) && (bottom_q < ey)) || ((ey < bottom_q) && (bottom_q < sy));
    ins = ((left_q <= sx) && (sx <= right_q) && (top_q <= sy) && (sy <= bottom_q)) ||
          ((left_q <= ex) && (ex <= right_q) && (top_q <= ey) && (ey <= bottom_q));
  end

  // Shared multiplier operands
  always_comb begin
    case (cmd_i.mul_sel)
      PROD_LSX_DY: begin mul_a = lsx_q; mul_b = dy_q; end
      PROD_RSX_DY: begin mul_a = rsx_q; mul_b = dy_q; end
      PROD_TSY_DX: begin mul_a = tsy_q; mul_b = dx_q; end
      PROD_BSY_DX: begin mul_a = bsy_q; mul_b = dx_q; end
      default:     begin mul_a = lsx_q; mul_b = dy_q; end
    endcase
    mul_p = PROD_WIDTH'(mul_a) * PROD_WIDTH'(mul_b);
  end

  // Crossing tests on the stored products
  always_comb begin
    dx_pos   = !dx_q[DIFF_WIDTH-1] && (dx_q != '0);
    dx_zero  = (dx_q == '0);
    dy_pos   = !dy_q[DIFF_WIDTH-1] && (dy_q != '0);
    dy_zero  = (dy_q == '0);
    cx1      = cross_test(prod_q[2], prod_q[0], prod_q[1], dy_pos, dy_zero);
    cx2      = cross_test(prod_q[3], prod_q[0], prod_q[1], dy_pos, dy_zero);
    cy1      = cross_test(prod_q[1], prod_q[2], prod_q[3], dx_pos, dx_zero);
    cy2      = cross_test(prod_q[0], prod_q[2], prod_q[3], dx_pos, dx_zero);
    edge_hit = (cx1_q && cx2_q && yin_q) || (cy1 && cy2 && xin_q) ||
               (xin_q && yin_q && (cx1_q || cx2_q) && (cy1 || cy2)) || ins_q;
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q   <= '0;
      right_q  <= '0;
      top_q    <= '0;
      bottom_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_LEFT:   left_q   <= cfg_wdata_i;
        REG_RIGHT:  right_q  <= cfg_wdata_i;
        REG_TOP:    top_q    <= cfg_wdata_i;
        REG_BOTTOM: bottom_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Polygon state and result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
      out_q <= 1'b0;
    end else begin
      if (cmd_i.capture && cmd_i.first) begin
        hit_q <= 1'b0;
      end else if (cmd_i.eval_y && edge_hit) begin
        hit_q <= 1'b1;
      end
      if (cmd_i.emit) begin
        out_q <= hit_q;
      end
    end
  end

  // Vertex store, edge setup and products
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      prev_x_q <= cur_x_q;
      prev_y_q <= cur_y_q;
      cur_x_q  <= vertex_x_i;
      cur_y_q  <= vertex_y_i;
      if (cmd_i.first) begin
        first_x_q <= vertex_x_i;
        first_y_q <= vertex_y_i;
      end
    end
    if (cmd_i.setup) begin
      dx_q  <= DIFF_WIDTH'(ex) - DIFF_WIDTH'(sx);
      dy_q  <= DIFF_WIDTH'(ey) - DIFF_WIDTH'(sy);
      lsx_q <= DIFF_WIDTH'(left_q) - DIFF_WIDTH'(sx);
      rsx_q <= DIFF_WIDTH'(right_q) - DIFF_WIDTH'(sx);
      tsy_q <= DIFF_WIDTH'(top_q) - DIFF_WIDTH'(sy);
      bsy_q <= DIFF_WIDTH'(bottom_q) - DIFF_WIDTH'(sy);
      xin_q <= xin;
      yin_q <= yin;
      ins_q <= ins;
    end
    if (cmd_i.mul) begin
      prod_q[cmd_i.mul_sel] <= mul_p;
    end
    if (cmd_i.eval_x) begin
      cx1_q <= cx1;
      cx2_q <= cx2;
    end
  end

  assign overlaps_o = out_q;

endmodule

`default_nettype wire

// File: sv/prot_ctrl.sv
// Controller: sequences capture, edge setup, four multiplies and two
// compare steps per edge, then the result handoff. Uses prot_pkg.
`timescale 1ns / 1ps
`default_nettype none

module prot_ctrl import prot_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  s_tvalid_i,
  input  wire logic  s_tlast_i,
  output logic       s_tready_o,
  output logic       m_tvalid_o,
  input  wire logic  m_tready_i,
  output prot_cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_MUL,
    ST_EVAL_X,
    ST_EVAL_Y,
    ST_EMIT
  } state_e;

  state_e    state_q, state_d;
  prod_sel_e mul_cnt_q, mul_cnt_d;
  logic      closing_q, closing_d, last_q, last_d, mid_q, mid_d;
  logic      m_valid_q, m_valid_d;

  // Next state and commands
  always_comb begin
    state_d   = state_q;
    mul_cnt_d = mul_cnt_q;
    closing_d = closing_q;
    last_d    = last_q;
    mid_d     = mid_q;
    cmd_o         = '0;
    cmd_o.closing = closing_q;
    cmd_o.mul_sel = mul_cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_tvalid_i) begin
          cmd_o.capture = 1'b1;
          cmd_o.first   = !mid_q;
          last_d        = s_tlast_i;
          mid_d         = !s_tlast_i;
          if (mid_q) begin
            closing_d = 1'b0;
            state_d   = ST_SETUP;
          end else if (s_tlast_i) begin
            closing_d = 1'b1;
            state_d   = ST_SETUP;
          end
        end
      end
      ST_SETUP: begin
        cmd_o.setup = 1'b1;
        mul_cnt_d   = PROD_LSX_DY;
        state_d     = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        if (mul_cnt_q == PROD_BSY_DX) begin
          state_d = ST_EVAL_X;
        end else begin
          mul_cnt_d = prod_sel_e'(mul_cnt_q + 2'd1);
        end
      end
      ST_EVAL_X: begin
        cmd_o.eval_x = 1'b1;
        state_d      = ST_EVAL_Y;
      end
      ST_EVAL_Y: begin
        cmd_o.eval_y = 1'b1;
        if (closing_q) begin
          state_d = ST_EMIT;
        end else if (last_q) begin
          closing_d = 1'b1;
          state_d   = ST_SETUP;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (!m_valid_q || m_tready_i) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    // Hold the result until taken
    if (cmd_o.emit) begin
      m_valid_d = 1'b1;
    end else if (m_tready_i) begin
      m_valid_d = 1'b0;
    end else begin
      m_valid_d = m_valid_q;
    end
  end

  // State and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      mul_cnt_q <= PROD_LSX_DY;
      closing_q <= 1'b0;
      last_q    <= 1'b0;
      mid_q     <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      mul_cnt_q <= mul_cnt_d;
      closing_q <= closing_d;
      last_q    <= last_d;
      mid_q     <= mid_d;
      m_valid_q <= m_valid_d;
    end
  end

  assign s_tready_o = (state_q == ST_IDLE);
  assign m_tvalid_o = m_valid_q;

endmodule

`default_nettype wire

// File: sv/prot_checker.sv
// Port checker for the polygon/rectangle overlap test core, bound to the top.
// Depends on prot_pkg and the assertion macros header.
`timescale 1ns / 1ps
`default_nettype none
`include "polygon_rect_overlap_test_core_macros.svh"

module prot_checker import prot_pkg::*; (
  input wire logic                      clk_i,
  input wire logic                      rst_ni,
  input wire logic                      s_axis_tvalid,
  input wire logic                      s_axis_tready,
  input wire logic [2*COORD_WIDTH-1:0]  s_axis_tdata,
  input wire logic                      s_axis_tlast,
  input wire logic                      m_axis_tvalid,
  input wire logic                      m_axis_tready,
  input wire logic [7:0]                m_axis_tdata,
  input wire logic                      cfg_we_i,
  input wire logic [CFG_ADDR_WIDTH-1:0] cfg_addr_i,
  input wire logic [COORD_WIDTH-1:0]    cfg_wdata_i
);

  // A stalled result holds
  `PROT_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")
  // A last vertex always runs the closing edge, so input stays blocked
  `PROT_ASSERT(a_last_busy, s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready ##1 !s_axis_tready, "input taken during closing edge")
  // Padding bits of the result stay zero
  `PROT_ASSERT(a_pad_zero, m_axis_tdata[7:1] == 7'd0, "result padding not zero")
  // No result is offered in reset
  `PROT_ASSERT_ALWAYS(a_reset_idle, !rst_ni |-> !m_axis_tvalid, "result valid during reset")

endmodule

bind polygon_rect_overlap_test_core prot_checker u_prot_checker (.*);

`default_nettype wire
